@@ hw/rtl/tmp3d_pkg.sv @@
package tmp3d_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int SPD_W   = 23;

  // Datapath widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int DIST_W = COORD_W + 1;
  localparam int SUM_W  = 2 * DIST_W;
  localparam int OPW    = (DIST_W > SPD_W) ? DIST_W : SPD_W;
  localparam int PROD_W = 2 * OPW;
  localparam int QUO_W  = SPD_W + 1;
  localparam int NUM_W  = QUO_W + OPW;
  localparam int BRK_W  = 2 * SPD_W;
  localparam int SGN_W  = BRK_W + 2;
  localparam int AX_W   = 2;

  // Axis codes
  localparam logic [AX_W-1:0] AX_X    = 2'd0;
  localparam logic [AX_W-1:0] AX_LAST = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXSPD = 1'b1;

  // Opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [SPD_W-1:0]          cur_speed;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF,
    ST_NDIV_GO, ST_NDIV_WAIT,
    ST_M1_GO, ST_M1_WAIT,
    ST_M2_GO, ST_M2_WAIT,
    ST_M3_GO, ST_M3_WAIT,
    ST_SQ_GO, ST_SQ_WAIT,
    ST_SQRT_GO, ST_SQRT_WAIT,
    ST_SPD1, ST_SPD2,
    ST_STM_GO, ST_STM_WAIT,
    ST_STD_GO, ST_STD_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_DIFF,
    CMD_NDIV_START, CMD_NDIV_CAP,
    CMD_M1_START, CMD_M1_CAP,
    CMD_M2_START, CMD_M2_CAP,
    CMD_M3_START, CMD_M3_CAP,
    CMD_SQ_START, CMD_SQ_CAP,
    CMD_SQRT_START, CMD_SQRT_CAP,
    CMD_SPD1, CMD_SPD2,
    CMD_STM_START, CMD_STM_CAP,
    CMD_STD_START, CMD_STD_CAP,
    CMD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [AX_W-1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic snap;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/tmp3d_mul.sv @@
// Sequential multiplier, one 4-bit digit of op_b per cycle, MSB first
module tmp3d_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tmp3d_pkg::OPW-1:0]    op_a,
  input  logic [tmp3d_pkg::OPW-1:0]    op_b,
  output logic                         done,
  output logic [tmp3d_pkg::PROD_W-1:0] prod
);

  localparam int OPW   = tmp3d_pkg::OPW;
  localparam int PW    = tmp3d_pkg::PROD_W;
  localparam int DIG_W = 4;
  localparam int MDIG  = (OPW + DIG_W - 1) / DIG_W;
  localparam int MBP   = MDIG * DIG_W;
  localparam int CNT_W = $clog2(MDIG);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PW-1:0]    acc_r;
  logic [OPW-1:0]   mcand_r;
  logic [MBP-1:0]   mplier_r;
  logic [OPW+DIG_W-1:0] pp;

  // partial product of one digit
  assign pp = {{DIG_W{1'b0}}, mcand_r} * {{OPW{1'b0}}, mplier_r[MBP-1 -: DIG_W]};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(MDIG - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= op_a;
      mplier_r <= {{(MBP-OPW){1'b0}}, op_b};
    end else if (busy_r) begin
      acc_r    <= {acc_r[PW-1-DIG_W:0], {DIG_W{1'b0}}} + {{(PW-OPW-DIG_W){1'b0}}, pp};
      mplier_r <= {mplier_r[MBP-1-DIG_W:0], {DIG_W{1'b0}}};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ hw/rtl/tmp3d_div.sv @@
// Restoring divider, one quotient bit per cycle; needs num < den * 2^QUO_W
module tmp3d_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tmp3d_pkg::NUM_W-1:0] num,
  input  logic [tmp3d_pkg::OPW-1:0]   den,
  output logic                        done,
  output logic [tmp3d_pkg::QUO_W-1:0] quo
);

  localparam int OPW   = tmp3d_pkg::OPW;
  localparam int QW    = tmp3d_pkg::QUO_W;
  localparam int NW    = tmp3d_pkg::NUM_W;
  localparam int CNT_W = $clog2(QW);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [OPW-1:0]   rem_r;
  logic [OPW-1:0]   den_r;
  logic [QW-1:0]    q_r;
  logic [OPW:0]     trial;
  logic [OPW:0]     diff;
  logic             ge;

  // one trial subtraction
  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NW-1:QW];
      q_r   <= num[QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[OPW-1:0] : trial[OPW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ hw/rtl/tmp3d_dp.sv @@
// Datapath: state, config, operand selection, square root, speed update and position step
module tmp3d_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tmp3d_pkg::dp_cmd_t              cmd,
  output tmp3d_pkg::dp_stat_t             stat,
  input  tmp3d_pkg::in_item_t             in_item,
  input  logic                            cfg_valid,
  input  logic [tmp3d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmp3d_pkg::SPD_W-1:0]     cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tmp3d_pkg::out_item_t            out_item
);

  localparam int CW    = tmp3d_pkg::COORD_W;
  localparam int SW    = tmp3d_pkg::SPD_W;
  localparam int DFW   = tmp3d_pkg::DIFF_W;
  localparam int DW    = tmp3d_pkg::DIST_W;
  localparam int SMW   = tmp3d_pkg::SUM_W;
  localparam int OPW   = tmp3d_pkg::OPW;
  localparam int PW    = tmp3d_pkg::PROD_W;
  localparam int QW    = tmp3d_pkg::QUO_W;
  localparam int NW    = tmp3d_pkg::NUM_W;
  localparam int BW    = tmp3d_pkg::BRK_W;
  localparam int GW    = tmp3d_pkg::SGN_W;
  localparam int SQC_W = $clog2(DW);

  localparam longint ACCEL_RAW  = (longint'(1) << FRAC_BITS) / 5;
  localparam longint MAXSPD_RAW = longint'(20) << FRAC_BITS;
  localparam logic [SW-1:0] ACCEL_RST  = ACCEL_RAW[SW-1:0];
  localparam logic [SW-1:0] MAXSPD_RST = MAXSPD_RAW[SW-1:0];

  // kept state and config
  logic [SW-1:0]          accel_r;
  logic [SW-1:0]          maxspd_r;
  logic signed [CW-1:0]   pos_r [3];
  logic [SW-1:0]          sp_r;
  logic                   out_valid_r;
  tmp3d_pkg::out_item_t   out_r;

  // per-item scratch
  logic signed [CW-1:0]   tgt_r [3];
  logic signed [DFW-1:0]  dif_r [3];
  logic [SW-1:0]          aeff_r;
  logic [SW-1:0]          n_r;
  logic [BW-1:0]          p1_r;
  logic [SW-1:0]          t_r;
  logic [BW-1:0]          brake_r;
  logic [SMW-1:0]         sum_r;
  logic [DW-1:0]          dist_r;
  logic                   snap_r;
  logic signed [SW+1:0]   s1_r;
  logic [NW-1:0]          num_r;

  // square root
  logic                   sq_busy_r;
  logic                   sq_done_r;
  logic [SQC_W-1:0]       sq_cnt_r;
  logic [SMW-1:0]         sq_rad_r;
  logic [DW+1:0]          sq_rem_r;
  logic [DW-1:0]          sq_root_r;
  logic [DW+3:0]          sq_sh;
  logic [DW+3:0]          sq_trial;
  logic [DW+3:0]          sq_diff;
  logic                   sq_ge;

  // shared units
  logic                   mul_start;
  logic [OPW-1:0]         mul_a;
  logic [OPW-1:0]         mul_b;
  logic                   mul_done;
  logic [PW-1:0]          mul_prod;
  logic                   div_start;
  logic [NW-1:0]          div_num;
  logic [OPW-1:0]         div_den;
  logic                   div_done;
  logic [QW-1:0]          div_quo;

  logic                   out_free;
  logic signed [DFW-1:0]  dif_sel;
  logic [DFW-1:0]         dif_mag;
  logic [SW-1:0]          n_less;

  // speed update terms
  logic signed [GW-1:0]   dist_s;
  logic signed [GW-1:0]   sp_s;
  logic signed [GW-1:0]   brake_s;
  logic signed [GW-1:0]   s1_s;
  logic signed [GW-1:0]   rem1;
  logic signed [GW-1:0]   rem2;
  logic signed [SW+1:0]   sp_e;
  logic signed [SW+1:0]   a_e;
  logic signed [SW+1:0]   max_e;
  logic signed [SW+1:0]   s1_nxt;
  logic signed [SW+1:0]   s2;
  logic [SW-1:0]          spd_nxt;

  // position step
  logic [QW-1:0]          step;
  logic signed [CW+1:0]   pos_e;
  logic signed [CW+1:0]   step_e;
  logic signed [CW+1:0]   np;
  logic signed [CW-1:0]   np_sat;

  assign out_free = !out_valid_r || !out_stall;

  // magnitude of the selected axis difference
  assign dif_sel = dif_r[cmd.axis];
  assign dif_mag = dif_sel[DFW-1] ? (~dif_sel + DFW'(1)) : dif_sel;
  assign n_less  = (n_r == '0) ? '0 : n_r - SW'(1);

  // multiplier operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd.op)
      tmp3d_pkg::CMD_M1_START: begin
        mul_start = 1'b1;
        mul_a     = OPW'(n_r);
        mul_b     = OPW'(sp_r);
      end
      tmp3d_pkg::CMD_M2_START: begin
        mul_start = 1'b1;
        mul_a     = OPW'(aeff_r);
        mul_b     = OPW'(n_r);
      end
      tmp3d_pkg::CMD_M3_START: begin
        mul_start = 1'b1;
        mul_a     = OPW'(t_r);
        mul_b     = OPW'(n_less);
      end
      tmp3d_pkg::CMD_SQ_START: begin
        mul_start = 1'b1;
        mul_a     = OPW'(dif_mag);
        mul_b     = OPW'(dif_mag);
      end
      tmp3d_pkg::CMD_STM_START: begin
        mul_start = 1'b1;
        mul_a     = OPW'(sp_r);
        mul_b     = OPW'(dif_mag);
      end
      default: begin
      end
    endcase
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      tmp3d_pkg::CMD_NDIV_START: begin
        div_start = 1'b1;
        div_num   = {{(NW-SW){1'b0}}, (sp_r > aeff_r) ? sp_r - SW'(1) : SW'(0)};
        div_den   = OPW'(aeff_r);
      end
      tmp3d_pkg::CMD_STD_START: begin
        div_start = 1'b1;
        div_num   = num_r;
        div_den   = OPW'(dist_r);
      end
      default: begin
      end
    endcase
  end

  tmp3d_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tmp3d_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // square root step, two radicand bits per cycle
  assign sq_sh    = {sq_rem_r, sq_rad_r[SMW-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_diff  = sq_sh - sq_trial;

  // speed tests: lower first, then raise against the lowered speed
  assign dist_s  = {{(GW-DW){1'b0}}, dist_r};
  assign sp_s    = {{(GW-SW){1'b0}}, sp_r};
  assign brake_s = {2'b00, brake_r};
  assign s1_s    = {{(GW-SW-2){s1_r[SW+1]}}, s1_r};
  assign rem1    = dist_s - sp_s;
  assign rem2    = dist_s - s1_s;
  assign sp_e    = {2'b00, sp_r};
  assign a_e     = {2'b00, aeff_r};
  assign max_e   = {2'b00, maxspd_r};
  assign s1_nxt  = (brake_s > rem1) ? sp_e - a_e : sp_e;
  assign s2      = (brake_s < rem2) ? s1_r + a_e : s1_r;

  always_comb begin
    if (s2 > max_e) begin
      spd_nxt = maxspd_r;
    end else if (s2[SW+1]) begin
      spd_nxt = '0;
    end else begin
      spd_nxt = s2[SW-1:0];
    end
  end

  // position step with saturation; no step when distance is zero
  assign step   = (dist_r == '0) ? '0 : div_quo;
  assign pos_e  = {{2{pos_r[cmd.axis][CW-1]}}, pos_r[cmd.axis]};
  assign step_e = {{(CW+2-QW){1'b0}}, step};
  assign np     = dif_sel[DFW-1] ? pos_e - step_e : pos_e + step_e;

  always_comb begin
    if (np[CW+1:CW-1] == 3'b000 || np[CW+1:CW-1] == 3'b111) begin
      np_sat = np[CW-1:0];
    end else if (np[CW+1]) begin
      np_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      np_sat = {1'b0, {(CW-1){1'b1}}};
    end
  end

  // kept state, config, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r     <= ACCEL_RST;
      maxspd_r    <= MAXSPD_RST;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      sq_busy_r   <= 1'b0;
      sq_done_r   <= 1'b0;
      sq_cnt_r    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tmp3d_pkg::CFG_ACCEL:  accel_r  <= cfg_wdata;
          tmp3d_pkg::CFG_MAXSPD: maxspd_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      // output valid: set on a new result, cleared when taken
      if (cmd.op == tmp3d_pkg::CMD_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // root iteration control
      if (cmd.op == tmp3d_pkg::CMD_SQRT_START) begin
        sq_busy_r <= 1'b1;
        sq_done_r <= 1'b0;
        sq_cnt_r  <= '0;
      end else if (sq_busy_r) begin
        sq_cnt_r <= sq_cnt_r + SQC_W'(1);
        if (sq_cnt_r == SQC_W'(DW - 1)) begin
          sq_busy_r <= 1'b0;
          sq_done_r <= 1'b1;
        end
      end
      case (cmd.op)
        tmp3d_pkg::CMD_LOAD: begin
          if (in_item.opcode == tmp3d_pkg::OP_LOAD) begin
            pos_r[0] <= in_item.coord_x;
            pos_r[1] <= in_item.coord_y;
            pos_r[2] <= in_item.coord_z;
          end
        end
        tmp3d_pkg::CMD_SPD2: begin
          if (snap_r) begin
            sp_r     <= '0;
            pos_r[0] <= tgt_r[0];
            pos_r[1] <= tgt_r[1];
            pos_r[2] <= tgt_r[2];
          end else begin
            sp_r <= spd_nxt;
          end
        end
        tmp3d_pkg::CMD_STD_CAP: begin
          if (div_done) begin
            pos_r[cmd.axis] <= np_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-item scratch registers
  always_ff @(posedge clk) begin
    if (cmd.op == tmp3d_pkg::CMD_SQRT_START) begin
      sq_rad_r  <= sum_r;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (sq_busy_r) begin
      sq_rad_r  <= {sq_rad_r[SMW-3:0], 2'b00};
      sq_rem_r  <= sq_ge ? sq_diff[DW+1:0] : sq_sh[DW+1:0];
      sq_root_r <= {sq_root_r[DW-2:0], sq_ge};
    end
    case (cmd.op)
      tmp3d_pkg::CMD_LOAD: begin
        tgt_r[0] <= in_item.coord_x;
        tgt_r[1] <= in_item.coord_y;
        tgt_r[2] <= in_item.coord_z;
      end
      tmp3d_pkg::CMD_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          dif_r[k] <= {tgt_r[k][CW-1], tgt_r[k]} - {pos_r[k][CW-1], pos_r[k]};
        end
        aeff_r <= (accel_r == '0) ? SW'(1) : accel_r;
        sum_r  <= '0;
      end
      tmp3d_pkg::CMD_NDIV_CAP: begin
        if (div_done) begin
          n_r <= (sp_r > aeff_r) ? div_quo[SW-1:0] : '0;
        end
      end
      tmp3d_pkg::CMD_M1_CAP: begin
        if (mul_done) begin
          p1_r <= mul_prod[BW-1:0];
        end
      end
      tmp3d_pkg::CMD_M2_CAP: begin
        if (mul_done) begin
          t_r <= mul_prod[SW-1:0];
        end
      end
      tmp3d_pkg::CMD_M3_CAP: begin
        if (mul_done) begin
          brake_r <= p1_r - mul_prod[BW:1];
        end
      end
      tmp3d_pkg::CMD_SQ_CAP: begin
        if (mul_done) begin
          sum_r <= sum_r + mul_prod[SMW-1:0];
        end
      end
      tmp3d_pkg::CMD_SQRT_CAP: begin
        if (sq_done_r) begin
          dist_r <= sq_root_r;
        end
      end
      tmp3d_pkg::CMD_SPD1: begin
        snap_r <= dist_s < sp_s;
        s1_r   <= s1_nxt;
      end
      tmp3d_pkg::CMD_STM_CAP: begin
        if (mul_done) begin
          num_r <= mul_prod[NW-1:0] + {{(NW-DW+1){1'b0}}, dist_r[DW-1:1]};
        end
      end
      tmp3d_pkg::CMD_OUT: begin
        if (out_free) begin
          out_r.pos_x     <= pos_r[0];
          out_r.pos_y     <= pos_r[1];
          out_r.pos_z     <= pos_r[2];
          out_r.cur_speed <= sp_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.mul_done  = mul_done;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sq_done_r;
  assign stat.snap      = snap_r;
  assign stat.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

@@ hw/rtl/tmp3d_ctrl.sv @@
// Sequencer: walks one step item through the datapath micro-operations
module tmp3d_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                in_opcode,
  input  tmp3d_pkg::dp_stat_t stat,
  output logic                in_ready,
  output tmp3d_pkg::dp_cmd_t  cmd
);

  localparam int AW = tmp3d_pkg::AX_W;

  tmp3d_pkg::state_t state_r;
  tmp3d_pkg::state_t state_nxt;
  logic [AW-1:0]     axis_r;
  logic [AW-1:0]     axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmp3d_pkg::ST_IDLE;
      axis_r  <= tmp3d_pkg::AX_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      tmp3d_pkg::ST_IDLE: begin
        if (in_fire && in_opcode == tmp3d_pkg::OP_STEP) begin
          state_nxt = tmp3d_pkg::ST_DIFF;
        end
      end
      tmp3d_pkg::ST_DIFF: begin
        axis_nxt  = tmp3d_pkg::AX_X;
        state_nxt = tmp3d_pkg::ST_NDIV_GO;
      end
      tmp3d_pkg::ST_NDIV_GO: state_nxt = tmp3d_pkg::ST_NDIV_WAIT;
      tmp3d_pkg::ST_NDIV_WAIT: begin
        if (stat.div_done) state_nxt = tmp3d_pkg::ST_M1_GO;
      end
      tmp3d_pkg::ST_M1_GO: state_nxt = tmp3d_pkg::ST_M1_WAIT;
      tmp3d_pkg::ST_M1_WAIT: begin
        if (stat.mul_done) state_nxt = tmp3d_pkg::ST_M2_GO;
      end
      tmp3d_pkg::ST_M2_GO: state_nxt = tmp3d_pkg::ST_M2_WAIT;
      tmp3d_pkg::ST_M2_WAIT: begin
        if (stat.mul_done) state_nxt = tmp3d_pkg::ST_M3_GO;
      end
      tmp3d_pkg::ST_M3_GO: state_nxt = tmp3d_pkg::ST_M3_WAIT;
      tmp3d_pkg::ST_M3_WAIT: begin
        if (stat.mul_done) state_nxt = tmp3d_pkg::ST_SQ_GO;
      end
      tmp3d_pkg::ST_SQ_GO: state_nxt = tmp3d_pkg::ST_SQ_WAIT;
      tmp3d_pkg::ST_SQ_WAIT: begin
        if (stat.mul_done) begin
          if (axis_r == tmp3d_pkg::AX_LAST) begin
            axis_nxt  = tmp3d_pkg::AX_X;
            state_nxt = tmp3d_pkg::ST_SQRT_GO;
          end else begin
            axis_nxt  = axis_r + AW'(1);
            state_nxt = tmp3d_pkg::ST_SQ_GO;
          end
        end
      end
      tmp3d_pkg::ST_SQRT_GO: state_nxt = tmp3d_pkg::ST_SQRT_WAIT;
      tmp3d_pkg::ST_SQRT_WAIT: begin
        if (stat.sqrt_done) state_nxt = tmp3d_pkg::ST_SPD1;
      end
      tmp3d_pkg::ST_SPD1: state_nxt = tmp3d_pkg::ST_SPD2;
      tmp3d_pkg::ST_SPD2: begin
        axis_nxt  = tmp3d_pkg::AX_X;
        state_nxt = stat.snap ? tmp3d_pkg::ST_OUT : tmp3d_pkg::ST_STM_GO;
      end
      tmp3d_pkg::ST_STM_GO: state_nxt = tmp3d_pkg::ST_STM_WAIT;
      tmp3d_pkg::ST_STM_WAIT: begin
        if (stat.mul_done) state_nxt = tmp3d_pkg::ST_STD_GO;
      end
      tmp3d_pkg::ST_STD_GO: state_nxt = tmp3d_pkg::ST_STD_WAIT;
      tmp3d_pkg::ST_STD_WAIT: begin
        if (stat.div_done) begin
          if (axis_r == tmp3d_pkg::AX_LAST) begin
            state_nxt = tmp3d_pkg::ST_OUT;
          end else begin
            axis_nxt  = axis_r + AW'(1);
            state_nxt = tmp3d_pkg::ST_STM_GO;
          end
        end
      end
      tmp3d_pkg::ST_OUT: begin
        if (stat.out_free) state_nxt = tmp3d_pkg::ST_IDLE;
      end
      default: state_nxt = tmp3d_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.axis = axis_r;
    cmd.op   = tmp3d_pkg::CMD_NONE;
    case (state_r)
      tmp3d_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) cmd.op = tmp3d_pkg::CMD_LOAD;
      end
      tmp3d_pkg::ST_DIFF:      cmd.op = tmp3d_pkg::CMD_DIFF;
      tmp3d_pkg::ST_NDIV_GO:   cmd.op = tmp3d_pkg::CMD_NDIV_START;
      tmp3d_pkg::ST_NDIV_WAIT: cmd.op = tmp3d_pkg::CMD_NDIV_CAP;
      tmp3d_pkg::ST_M1_GO:     cmd.op = tmp3d_pkg::CMD_M1_START;
      tmp3d_pkg::ST_M1_WAIT:   cmd.op = tmp3d_pkg::CMD_M1_CAP;
      tmp3d_pkg::ST_M2_GO:     cmd.op = tmp3d_pkg::CMD_M2_START;
      tmp3d_pkg::ST_M2_WAIT:   cmd.op = tmp3d_pkg::CMD_M2_CAP;
      tmp3d_pkg::ST_M3_GO:     cmd.op = tmp3d_pkg::CMD_M3_START;
      tmp3d_pkg::ST_M3_WAIT:   cmd.op = tmp3d_pkg::CMD_M3_CAP;
      tmp3d_pkg::ST_SQ_GO:     cmd.op = tmp3d_pkg::CMD_SQ_START;
      tmp3d_pkg::ST_SQ_WAIT:   cmd.op = tmp3d_pkg::CMD_SQ_CAP;
      tmp3d_pkg::ST_SQRT_GO:   cmd.op = tmp3d_pkg::CMD_SQRT_START;
      tmp3d_pkg::ST_SQRT_WAIT: cmd.op = tmp3d_pkg::CMD_SQRT_CAP;
      tmp3d_pkg::ST_SPD1:      cmd.op = tmp3d_pkg::CMD_SPD1;
      tmp3d_pkg::ST_SPD2:      cmd.op = tmp3d_pkg::CMD_SPD2;
      tmp3d_pkg::ST_STM_GO:    cmd.op = tmp3d_pkg::CMD_STM_START;
      tmp3d_pkg::ST_STM_WAIT:  cmd.op = tmp3d_pkg::CMD_STM_CAP;
      tmp3d_pkg::ST_STD_GO:    cmd.op = tmp3d_pkg::CMD_STD_START;
      tmp3d_pkg::ST_STD_WAIT:  cmd.op = tmp3d_pkg::CMD_STD_CAP;
      tmp3d_pkg::ST_OUT:       cmd.op = tmp3d_pkg::CMD_OUT;
      default:                 cmd.op = tmp3d_pkg::CMD_NONE;
    endcase
  end

endmodule

@@ hw/rtl/trapezoid_motion_profile_3d_unit.sv @@
// Trapezoidal point-to-point motion profile in 3D, signed Q16.16 positions.
// A load item (opcode 0) sets the position and gives no result.
// A step item (opcode 1) runs one item at a time through a sequencer and a
// shared datapath: a divide for the braking term count, three multiplies
// for the braking distance, three squares, a square root, then per axis
// one multiply and one divide for the step. After a snap the position is
// set to the target and the per-axis steps are skipped. The multiplier is
// 4-bit-per-cycle; the divider and root are 1-bit-per-cycle. The result
// sits in an output register, so the next item is taken while it waits.
// Configuration writes are always ready; write only while idle.
module trapezoid_motion_profile_3d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tmp3d_pkg::in_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tmp3d_pkg::out_item_t            out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tmp3d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmp3d_pkg::SPD_W-1:0]     cfg_wdata
);

  logic                in_ready;
  logic                in_fire;
  tmp3d_pkg::dp_cmd_t  cmd;
  tmp3d_pkg::dp_stat_t stat;

  assign in_stall  = !in_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  tmp3d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_opcode (in_item.opcode),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  tmp3d_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a result only appears after the output command
  a_out_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op) == tmp3d_pkg::CMD_OUT)
    else $error("result raised without output command");

  // items are latched only when accepted in idle
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tmp3d_pkg::CMD_LOAD) |-> (in_fire && in_ready))
    else $error("item latched without accept");

  // axis index stays within the three axes
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.axis <= tmp3d_pkg::AX_LAST)
    else $error("axis index out of range");

endmodule
